>>> design/fdc_pkg.sv
package fdc_pkg;

  localparam int ADDR_BITS_DEF = 24;

  localparam int OUT_ADDR_W = 24;
  localparam int LINE_W     = 16;
  localparam int COL_W      = 16;
  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd200;

  // opcode word classes (top two bits)
  localparam logic [1:0] OPC_PACKETS  = 2'd0;
  localparam logic [1:0] OPC_UNUSED   = 2'd1;
  localparam logic [1:0] OPC_LASTPIX  = 2'd2;
  localparam logic [1:0] OPC_LINESKIP = 2'd3;
  localparam int         OPC_LSB      = 14;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // chunk end codes
  localparam logic [1:0] END_NONE  = 2'd0;
  localparam logic [1:0] END_LINES = 2'd1;
  localparam logic [1:0] END_ZERO  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LC_HI  = 4'd1,
    PH_OP_LO  = 4'd2,
    PH_OP_HI  = 4'd3,
    PH_SKIP   = 4'd4,
    PH_COUNT  = 4'd5,
    PH_LIT    = 4'd6,
    PH_FILLLO = 4'd7,
    PH_FILLHI = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    JOB_LIT     = 2'd0,
    JOB_LASTPIX = 2'd1,
    JOB_FILL    = 2'd2,
    JOB_END     = 2'd3
  } job_src_t;

  // one classified request between parser and address unit
  typedef struct packed {
    job_src_t          src;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [15:0]       value;
    logic [7:0]        fill_words;
    logic [1:0]        chunk_end;
  } job_t;

endpackage

>>> design/fdc_front.sv
module fdc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          chunk_start,
  output logic          push,
  output fdc_pkg::job_t job
);

  fdc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] lines_left_r, lines_left_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] packets_r, packets_nxt;
  logic [15:0] col_r, col_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic [7:0]  fill_r, fill_nxt;

  logic [15:0] word;
  logic [15:0] lines_dec;
  logic [15:0] packets_dec;
  logic [7:0]  lit_dec;
  logic        last_line;
  logic        last_packet;

  assign word        = {data_byte, hold_r};
  assign lines_dec   = lines_left_r - 16'd1;
  assign packets_dec = packets_r - 16'd1;
  assign lit_dec     = lit_r - 8'd1;
  assign last_line   = (lines_dec == 16'd0);
  assign last_packet = (packets_dec == 16'd0);

  // next state and datapath
  always_comb begin
    phase_nxt      = phase_r;
    lines_left_nxt = lines_left_r;
    line_nxt       = line_r;
    packets_nxt    = packets_r;
    col_nxt        = col_r;
    hold_nxt       = hold_r;
    lit_nxt        = lit_r;
    fill_nxt       = fill_r;
    if (acc && chunk_start) begin
      hold_nxt    = data_byte;
      line_nxt    = '0;
      packets_nxt = '0;
      col_nxt     = '0;
      lit_nxt     = '0;
      fill_nxt    = '0;
      phase_nxt   = fdc_pkg::PH_LC_HI;
    end else if (acc) begin
      unique case (phase_r)
        fdc_pkg::PH_LC_HI: begin
          lines_left_nxt = word;
          phase_nxt = (word == 16'd0) ? fdc_pkg::PH_DONE : fdc_pkg::PH_OP_LO;
        end
        fdc_pkg::PH_OP_LO: begin
          hold_nxt  = data_byte;
          phase_nxt = fdc_pkg::PH_OP_HI;
        end
        fdc_pkg::PH_OP_HI: begin
          phase_nxt = fdc_pkg::PH_OP_LO;
          unique case (word[fdc_pkg::OPC_LSB +: 2])
            fdc_pkg::OPC_PACKETS: begin
              packets_nxt = word;
              col_nxt     = '0;
              if (word == 16'd0) begin
                line_nxt       = line_r + 16'd1;
                lines_left_nxt = lines_dec;
                phase_nxt = last_line ? fdc_pkg::PH_DONE : fdc_pkg::PH_OP_LO;
              end else begin
                phase_nxt = fdc_pkg::PH_SKIP;
              end
            end
            fdc_pkg::OPC_LINESKIP: line_nxt = line_r - word;
            fdc_pkg::OPC_LASTPIX,
            fdc_pkg::OPC_UNUSED: ;
            default: ;
          endcase
        end
        fdc_pkg::PH_SKIP: begin
          col_nxt   = col_r + {8'd0, data_byte};
          phase_nxt = fdc_pkg::PH_COUNT;
        end
        fdc_pkg::PH_COUNT: begin
          if (data_byte == 8'd0) begin
            phase_nxt = fdc_pkg::PH_DONE;
          end else if (!data_byte[7]) begin
            lit_nxt   = {data_byte[6:0], 1'b0};
            phase_nxt = fdc_pkg::PH_LIT;
          end else begin
            fill_nxt  = 8'd0 - data_byte;
            phase_nxt = fdc_pkg::PH_FILLLO;
          end
        end
        fdc_pkg::PH_LIT, fdc_pkg::PH_FILLHI: begin
          if (phase_r == fdc_pkg::PH_LIT) begin
            col_nxt = col_r + 16'd1;
            lit_nxt = lit_dec;
          end else begin
            col_nxt = col_r + {7'd0, fill_r, 1'b0};
          end
          // packet finishes on the last literal byte or on any fill
          if (phase_r == fdc_pkg::PH_FILLHI || lit_dec == 8'd0) begin
            packets_nxt = packets_dec;
            if (last_packet) begin
              line_nxt       = line_r + 16'd1;
              lines_left_nxt = lines_dec;
              phase_nxt = last_line ? fdc_pkg::PH_DONE : fdc_pkg::PH_OP_LO;
            end else begin
              phase_nxt = fdc_pkg::PH_SKIP;
            end
          end
        end
        fdc_pkg::PH_FILLLO: begin
          hold_nxt  = data_byte;
          phase_nxt = fdc_pkg::PH_FILLHI;
        end
        fdc_pkg::PH_IDLE, fdc_pkg::PH_DONE: ;
        default: ;
      endcase
    end
  end

  // request towards the address unit
  always_comb begin
    logic ends_chunk;
    ends_chunk      = (phase_r == fdc_pkg::PH_FILLHI || lit_dec == 8'd0)
                      && last_packet && last_line;
    push            = 1'b0;
    job.src         = fdc_pkg::JOB_END;
    job.line        = line_r;
    job.col         = col_r;
    job.value       = '0;
    job.fill_words  = '0;
    job.chunk_end   = fdc_pkg::END_NONE;
    if (acc && !chunk_start) begin
      unique case (phase_r)
        fdc_pkg::PH_LC_HI: begin
          push          = (word == 16'd0);
          job.chunk_end = fdc_pkg::END_LINES;
        end
        fdc_pkg::PH_OP_HI: begin
          if (word[fdc_pkg::OPC_LSB +: 2] == fdc_pkg::OPC_PACKETS) begin
            push          = (word == 16'd0) && last_line;
            job.chunk_end = fdc_pkg::END_LINES;
          end else if (word[fdc_pkg::OPC_LSB +: 2] == fdc_pkg::OPC_LASTPIX) begin
            push      = 1'b1;
            job.src   = fdc_pkg::JOB_LASTPIX;
            job.value = {8'd0, word[7:0]};
          end
        end
        fdc_pkg::PH_COUNT: begin
          push          = (data_byte == 8'd0);
          job.chunk_end = fdc_pkg::END_ZERO;
        end
        fdc_pkg::PH_LIT: begin
          push          = 1'b1;
          job.src       = fdc_pkg::JOB_LIT;
          job.value     = {8'd0, data_byte};
          job.chunk_end = ends_chunk ? fdc_pkg::END_LINES : fdc_pkg::END_NONE;
        end
        fdc_pkg::PH_FILLHI: begin
          push           = 1'b1;
          job.src        = fdc_pkg::JOB_FILL;
          job.value      = word;
          job.fill_words = fill_r;
          job.chunk_end  = ends_chunk ? fdc_pkg::END_LINES : fdc_pkg::END_NONE;
        end
        fdc_pkg::PH_IDLE, fdc_pkg::PH_OP_LO, fdc_pkg::PH_SKIP,
        fdc_pkg::PH_FILLLO, fdc_pkg::PH_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fdc_pkg::PH_IDLE;
      lines_left_r <= '0;
      line_r       <= '0;
      packets_r    <= '0;
      col_r        <= '0;
      hold_r       <= '0;
      lit_r        <= '0;
      fill_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      lines_left_r <= lines_left_nxt;
      line_r       <= line_nxt;
      packets_r    <= packets_nxt;
      col_r        <= col_nxt;
      hold_r       <= hold_nxt;
      lit_r        <= lit_nxt;
      fill_r       <= fill_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_closes_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.src == fdc_pkg::JOB_END |-> phase_nxt == fdc_pkg::PH_DONE)
    else $error("end-of-chunk request without closing the parser");
`endif

endmodule

>>> design/fdc_queue.sv
module fdc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fdc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output fdc_pkg::job_t head
);

  fdc_pkg::job_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue read while empty");
`endif

endmodule

>>> design/fdc_back.sv
module fdc_back #(
  parameter int ADDR_BITS = fdc_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [fdc_pkg::DIM_W-1:0]       cfg_wdata,
  input  logic                            job_valid,
  input  fdc_pkg::job_t                   job,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [fdc_pkg::OUT_ADDR_W-1:0]  out_address,
  output logic [15:0]                     out_value,
  output logic [7:0]                      out_fill_words,
  output logic                            out_oof,
  output logic [1:0]                      out_chunk_end
);

  localparam int AW_EFF = (ADDR_BITS < fdc_pkg::OUT_ADDR_W) ? ADDR_BITS
                                                            : fdc_pkg::OUT_ADDR_W;
  localparam logic [fdc_pkg::OUT_ADDR_W-1:0] ADDR_MASK =
    {fdc_pkg::OUT_ADDR_W{1'b1}} >> (fdc_pkg::OUT_ADDR_W - AW_EFF);
  localparam int PROD_W = fdc_pkg::LINE_W + fdc_pkg::DIM_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [fdc_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [fdc_pkg::DIM_W-1:0] height_r, height_nxt;

  logic                           valid_r;
  logic [1:0]                     kind_r, kind_nxt;
  logic [fdc_pkg::OUT_ADDR_W-1:0] addr_r, addr_nxt;
  logic [15:0]                    value_r;
  logic [7:0]                     words_r;
  logic                           oof_r, oof_nxt;
  logic [1:0]                     end_r;

  logic [PROD_W-1:0] prod;
  logic [15:0]       col_sel;
  logic [SUM_W-1:0]  sum;
  logic              line_oof;
  logic [16:0]       fill_reach;

  assign pop = job_valid && (!valid_r || out_ready);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        fdc_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        fdc_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prod       = PROD_W'(job.line) * PROD_W'(width_r);
    col_sel    = (job.src == fdc_pkg::JOB_LASTPIX) ? {4'd0, width_r - 12'd1} : job.col;
    sum        = {1'b0, prod} + {{(SUM_W - 16){1'b0}}, col_sel};
    line_oof   = (job.line >= {4'd0, height_r});
    fill_reach = {1'b0, job.col} + {8'd0, job.fill_words, 1'b0};
    kind_nxt   = fdc_pkg::KIND_BYTE;
    addr_nxt   = sum[fdc_pkg::OUT_ADDR_W-1:0] & ADDR_MASK;
    oof_nxt    = line_oof;
    case (job.src)
      fdc_pkg::JOB_LIT: oof_nxt = line_oof || (job.col >= {4'd0, width_r});
      fdc_pkg::JOB_LASTPIX: begin
        // zero width: column minus one wraps to all ones
        if (width_r == '0) begin
          addr_nxt = ADDR_MASK;
        end
        oof_nxt = line_oof || (width_r == '0);
      end
      fdc_pkg::JOB_FILL: begin
        kind_nxt = fdc_pkg::KIND_FILL;
        oof_nxt  = line_oof || (fill_reach > {5'd0, width_r});
      end
      default: begin
        kind_nxt = fdc_pkg::KIND_END;
        addr_nxt = '0;
        oof_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      value_r <= job.value;
      words_r <= job.fill_words;
      oof_r   <= oof_nxt;
      end_r   <= job.chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      width_r  <= fdc_pkg::FRAME_WIDTH_RST;
      height_r <= fdc_pkg::FRAME_HEIGHT_RST;
    end else begin
      valid_r  <= pop || (valid_r && !out_ready);
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_address    = addr_r;
  assign out_value      = value_r;
  assign out_fill_words = words_r;
  assign out_oof        = oof_r;
  assign out_chunk_end  = end_r;

`ifndef SYNTHESIS
  a_end_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == fdc_pkg::KIND_END |->
      addr_r == '0 && !oof_r && words_r == '0 && end_r != fdc_pkg::END_NONE)
    else $error("end-of-chunk result carries write fields");
`endif

endmodule

>>> design/flc_delta_chunk_decoder_core.sv
// Path: the result request for a payload byte is written into the queue as the byte is accepted,
//   then loaded into the output register when the address unit pops it from the queue.
// Throughput: one payload byte per cycle, sustained while the result side keeps taking requests;
//   the address unit needs one multiply-add per request and is fully pipelined.
// A two-entry request queue parts the byte parser from the address unit.
// Reset (rst_n low, synchronous) returns the parser to idle, empties the queue and output,
//   and loads frame_width 320 and frame_height 200.
module flc_delta_chunk_decoder_core #(
  parameter int ADDR_BITS = fdc_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // payload bytes
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] data_byte
  input  logic                          in_tuser,  // [0] chunk_start
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [23:0] address, [39:24] value, [47:40] fill_words, [48] out_of_frame, [55:49] zero
  output logic [55:0]                   out_tdata,
  output logic [3:0]                    out_tuser, // [1:0] kind, [3:2] chunk_end
  // configuration writes
  input  logic                          cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [fdc_pkg::DIM_W-1:0]     cfg_wdata
);

  logic          acc;
  logic          push;
  fdc_pkg::job_t push_job;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  fdc_pkg::job_t head;

  logic [1:0]                     kind;
  logic [fdc_pkg::OUT_ADDR_W-1:0] address;
  logic [15:0]                    value;
  logic [7:0]                     fill_words;
  logic                           oof;
  logic [1:0]                     chunk_end;

  // hold the input back only while the queue has no room
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // parse bytes, classify each into at most one request
  fdc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_tdata),
    .chunk_start (in_tuser),
    .push        (push),
    .job         (push_job)
  );

  // decouple parser from the address unit
  fdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  // compute frame address and bounds flag, register the result
  fdc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .job_valid      (q_valid),
    .job            (head),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (kind),
    .out_address    (address),
    .out_value      (value),
    .out_fill_words (fill_words),
    .out_oof        (oof),
    .out_chunk_end  (chunk_end)
  );

  // pack the result request
  assign out_tdata = {7'd0, oof, fill_words, value, address};
  assign out_tuser = {chunk_end, kind};

endmodule
